// ===== hdl/pcc_pkg.sv =====
// Shared constants, codes and control types of the palette color cycler.
package pcc_pkg;

	// Default block dimensions
	localparam int PALETTE_DEPTH_DEF = 32;
	localparam int RANGE_COUNT_DEF   = 3;

	// Field widths
	localparam int OP_W     = 2;
	localparam int IDX_W    = 5;
	localparam int COLOR_W  = 12;
	localparam int RATE_W   = 15;
	localparam int BOUNDS_W = 10;
	localparam int PHASE_W  = 15;
	localparam int CFG_DATA_W = 15;

	// Stream widths
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = OP_W;
	localparam int M_TDATA_W = 16;

	// Phase arithmetic: one step per tick
	localparam int ONE_PER_TICK = 16384;
	localparam int ONE_PER_SEC  = ONE_PER_TICK / 60;
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(ONE_PER_SEC * 10);
	localparam logic [BOUNDS_W-1:0] BOUNDS_FIRST_RESET = BOUNDS_W'(103);
	localparam logic [BOUNDS_W-1:0] BOUNDS_RESET = '0;

	// Configuration register indexes
	localparam int CFG_ENABLE     = 0;
	localparam int CFG_SUPPRESS   = 1;
	localparam int CFG_RANGE_BASE = 2;

	// Input beat kinds
	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_in;
		logic exec;
		logic range_clr;
		logic step;
		logic rotate;
		logic range_next;
		logic load_out;
	} pcc_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic tick_go;
		logic fire;
		logic last_range;
	} pcc_sts_t;

endpackage

// ===== hdl/pcc_ctrl.sv =====
// Controller state machine of the palette color cycler.
module pcc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output pcc_pkg::pcc_cmd_t  cmd,
	input  pcc_pkg::pcc_sts_t  sts
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_STEP = 5'b00100,
		S_ROT  = 5'b01000,
		S_RESP = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	// Sequence one beat: execute, walk the ranges on an enabled tick, then post the result
	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				cmd.range_clr = 1'b1;
				state_d = sts.tick_go ? S_STEP : S_RESP;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				if (sts.fire) begin
					state_d = S_ROT;
				end else if (sts.last_range) begin
					state_d = S_RESP;
				end else begin
					cmd.range_next = 1'b1;
				end
			end
			S_ROT: begin
				cmd.rotate = 1'b1;
				if (sts.last_range) begin
					state_d = S_RESP;
				end else begin
					cmd.range_next = 1'b1;
					state_d = S_STEP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hdl/pcc_datapath.sv =====
// Datapath of the palette color cycler: palette, range registers and phase accumulators.
module pcc_datapath #(
	parameter int PALETTE_DEPTH = pcc_pkg::PALETTE_DEPTH_DEF,
	parameter int RANGE_COUNT   = pcc_pkg::RANGE_COUNT_DEF,
	parameter int CFG_IDX_W     = $clog2(2 + 2 * RANGE_COUNT)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [CFG_IDX_W-1:0]             cfg_index,
	input  logic [pcc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [pcc_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic [pcc_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic [pcc_pkg::M_TDATA_W-1:0]    m_tdata,
	input  pcc_pkg::pcc_cmd_t                cmd,
	output pcc_pkg::pcc_sts_t                sts
);

	localparam int IW = $clog2(PALETTE_DEPTH);
	localparam int RW = (RANGE_COUNT > 1) ? $clog2(RANGE_COUNT) : 1;
	localparam int FIELD_SPAN = 1 << pcc_pkg::IDX_W;
	localparam int CW = pcc_pkg::COLOR_W;
	localparam int PW = pcc_pkg::PHASE_W;

	// Configuration registers
	logic                            enable_q;
	logic                            suppress_q;
	logic [pcc_pkg::RATE_W-1:0]      rate_q   [RANGE_COUNT];
	logic [pcc_pkg::BOUNDS_W-1:0]    bounds_q [RANGE_COUNT];
	logic [PW-1:0]                   phase_q  [RANGE_COUNT];

	// Beat and working registers
	pcc_pkg::op_t                    op_q;
	logic [IW-1:0]                   idx_q;
	logic [CW-1:0]                   color_q;
	logic [CW-1:0]                   rd_q;
	logic                            any_q;
	logic [RW-1:0]                   rng_q;
	logic [pcc_pkg::M_TDATA_W-1:0]   out_q;
	logic [CW-1:0]                   pal_q [PALETTE_DEPTH];

	// Index wrap table: field value modulo the palette depth
	logic [IW-1:0] wrap_tbl [FIELD_SPAN];
	for (genvar g = 0; g < FIELD_SPAN; g++) begin : g_wrap
		assign wrap_tbl[g] = IW'(g % PALETTE_DEPTH);
	end

	// Current range
	logic [pcc_pkg::RATE_W-1:0]   rate_cur;
	logic [pcc_pkg::BOUNDS_W-1:0] bounds_cur;
	logic [PW-1:0]                phase_cur;
	logic [PW-1:0]                rate_sat;
	logic [PW-1:0]                phase_sum;
	logic                         active;
	logic [IW-1:0]                lo;
	logic [IW-1:0]                hi;
	logic [IW-1:0]                rd_addr;
	logic [CW-1:0]                rd_data;

	assign rate_cur   = rate_q[rng_q];
	assign bounds_cur = bounds_q[rng_q];
	assign phase_cur  = phase_q[rng_q];
	assign active     = (rate_cur != '0);
	assign rate_sat   = (rate_cur > PW'(pcc_pkg::ONE_PER_TICK)) ?
	                    PW'(pcc_pkg::ONE_PER_TICK) : PW'(rate_cur);
	assign phase_sum  = phase_cur + rate_sat;
	assign lo = wrap_tbl[bounds_cur[2*pcc_pkg::IDX_W-1:pcc_pkg::IDX_W]];
	assign hi = wrap_tbl[bounds_cur[pcc_pkg::IDX_W-1:0]];

	// Shared palette read port: top of range on rotate, beat index otherwise
	assign rd_addr = cmd.rotate ? hi : idx_q;
	assign rd_data = pal_q[rd_addr];

	assign sts.tick_go    = (op_q == pcc_pkg::OP_TICK) && enable_q;
	assign sts.fire       = active && phase_sum[PW-1];
	assign sts.last_range = (rng_q == RW'(RANGE_COUNT - 1));

	assign m_tdata = out_q;

	// Write global configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			suppress_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_IDX_W'(pcc_pkg::CFG_ENABLE)) begin
				enable_q <= cfg_data[0];
			end
			if (cfg_index == CFG_IDX_W'(pcc_pkg::CFG_SUPPRESS)) begin
				suppress_q <= cfg_data[0];
			end
		end
	end

	// Per-range rate, bounds and phase
	for (genvar r = 0; r < RANGE_COUNT; r++) begin : g_range
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rate_q[r]   <= pcc_pkg::RATE_RESET;
				bounds_q[r] <= (r == 0) ? pcc_pkg::BOUNDS_FIRST_RESET : pcc_pkg::BOUNDS_RESET;
			end else if (cfg_we) begin
				if (cfg_index == CFG_IDX_W'(pcc_pkg::CFG_RANGE_BASE + 2 * r)) begin
					rate_q[r] <= cfg_data[pcc_pkg::RATE_W-1:0];
				end
				if (cfg_index == CFG_IDX_W'(pcc_pkg::CFG_RANGE_BASE + 2 * r + 1)) begin
					bounds_q[r] <= cfg_data[pcc_pkg::BOUNDS_W-1:0];
				end
			end
		end

		// Advance the phase; drop one step when it fires
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				phase_q[r] <= '0;
			end else if (cmd.step && active && rng_q == RW'(r)) begin
				phase_q[r] <= {1'b0, phase_sum[PW-2:0]};
			end
		end
	end

	// Range counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q <= '0;
		end else if (cmd.range_clr) begin
			rng_q <= '0;
		end else if (cmd.range_next) begin
			rng_q <= rng_q + RW'(1);
		end
	end

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= pcc_pkg::op_t'(s_tuser);
			idx_q   <= wrap_tbl[s_tdata[pcc_pkg::IDX_W-1:0]];
			color_q <= s_tdata[pcc_pkg::IDX_W +: CW];
		end
	end

	// Read data and changed flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			any_q <= 1'b0;
		end else if (cmd.exec) begin
			rd_q  <= (op_q == pcc_pkg::OP_READ) ? rd_data : '0;
			any_q <= 1'b0;
		end else if (cmd.step && sts.fire) begin
			any_q <= 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= {(pcc_pkg::M_TDATA_W - CW - 1)'(0), rd_q, any_q & ~suppress_q};
		end
	end

	// Palette entries: beat write, or rotate up by one inside the range
	for (genvar j = 0; j < PALETTE_DEPTH; j++) begin : g_pal
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pal_q[j] <= '0;
			end else if (cmd.rotate) begin
				if (lo == IW'(j)) begin
					pal_q[j] <= rd_data;
				end else if (j > 0) begin
					if (IW'(j) > lo && IW'(j) <= hi) begin
						pal_q[j] <= pal_q[(j > 0) ? j - 1 : 0];
					end
				end
			end else if (cmd.exec && op_q == pcc_pkg::OP_WRITE && idx_q == IW'(j)) begin
				pal_q[j] <= color_q;
			end
		end
	end

endmodule

// ===== hdl/palette_color_cycler_top.sv =====
// Sequencing: any beat but an enabled tick goes from acceptance through the execute and
// response states; an enabled tick also steps each range and rotates each range that fires.
// One beat at a time, held by the range walk through the single phase adder and the
// palette rotate; a new beat is taken while the last result waits.
// Reset (arst_n low, asynchronous): palette and phases zero, registers to their defaults,
// no result pending.
module palette_color_cycler_top #(
	parameter int PALETTE_DEPTH = pcc_pkg::PALETTE_DEPTH_DEF,
	parameter int RANGE_COUNT   = pcc_pkg::RANGE_COUNT_DEF,
	parameter int CFG_IDX_W     = $clog2(2 + 2 * RANGE_COUNT)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [CFG_IDX_W-1:0]             cfg_index,
	input  logic [pcc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pcc_pkg::S_TDATA_W-1:0]    s_tdata,  // entry_index[4:0], color_value[16:5]
	input  logic [pcc_pkg::S_TUSER_W-1:0]    s_tuser,  // op[1:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pcc_pkg::M_TDATA_W-1:0]    m_tdata   // changed[0], read_color[12:1]
);

	pcc_pkg::pcc_cmd_t cmd;
	pcc_pkg::pcc_sts_t sts;

	// Sequencer
	pcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Palette and ranges
	pcc_datapath #(
		.PALETTE_DEPTH (PALETTE_DEPTH),
		.RANGE_COUNT   (RANGE_COUNT),
		.CFG_IDX_W     (CFG_IDX_W)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== hdl/pcc_checker.sv =====
// Port-level checks of the palette color cycler, bound to the top level.
module pcc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [pcc_pkg::M_TDATA_W-1:0]  m_tdata
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// A result never carries both a change flag and read data
	a_out_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[pcc_pkg::COLOR_W:1] != '0))
		else $error("changed and read color both set");

	// Take one beat at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a beat was taken");

	// Padding bits of a result stay zero
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[pcc_pkg::M_TDATA_W-1:pcc_pkg::COLOR_W+1] == '0)
		else $error("result padding not zero");

endmodule

bind palette_color_cycler_top pcc_checker u_pcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== dv/palette_color_cycler_top_tb.sv =====
// Self-checking testbench for the palette color cycler: driver, monitor and predictor.
`timescale 1ns / 100ps

module palette_color_cycler_top_tb;

	localparam int CFG_IDX_W = $clog2(2 + 2 * pcc_pkg::RANGE_COUNT_DEF);
	localparam logic [pcc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_AT_BEAT = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic [pcc_pkg::OP_W-1:0]    op;
		logic [pcc_pkg::IDX_W-1:0]   idx;
		logic [pcc_pkg::COLOR_W-1:0] color;
	} palette_cmd_t;

	typedef struct packed {
		logic                        changed;
		logic [pcc_pkg::COLOR_W-1:0] color;
	} palette_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [pcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [pcc_pkg::S_TDATA_W-1:0] s_tdata = '0;  // entry_index[4:0], color_value[16:5]
	logic [pcc_pkg::S_TUSER_W-1:0] s_tuser = '0;  // op[1:0]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [pcc_pkg::M_TDATA_W-1:0] m_tdata;  // changed[0], read_color[12:1]

	// Predictor state
	logic                         model_enable;
	logic                         model_suppress;
	logic [pcc_pkg::RATE_W-1:0]   model_rate [pcc_pkg::RANGE_COUNT_DEF];
	logic [pcc_pkg::BOUNDS_W-1:0] model_bounds [pcc_pkg::RANGE_COUNT_DEF];
	logic [pcc_pkg::PHASE_W-1:0]  model_phase [pcc_pkg::RANGE_COUNT_DEF];
	logic [pcc_pkg::COLOR_W-1:0]  model_palette [pcc_pkg::PALETTE_DEPTH_DEF];

	palette_cmd_t   cmd_queue [$];
	palette_reply_t replies_due [$];
	palette_reply_t want;
	int mismatch_count = 0;
	int beats_in = 0;
	int unsigned src_gap = 0;
	int unsigned sink_gap = 0;
	int unsigned draw;
	int hold_left = 0;
	logic hold_done = 1'b0;
	logic src_idle = 1'b0;
	logic sink_idle = 1'b0;

	palette_color_cycler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// Advance the palette model by one command and return the reply it should produce
	function automatic palette_reply_t apply_palette_cmd(input palette_cmd_t cmd);
		palette_reply_t reply;
		logic any;
		int r;
		int j;
		int unsigned rate;
		int unsigned acc;
		logic [pcc_pkg::IDX_W-1:0] lo;
		logic [pcc_pkg::IDX_W-1:0] hi;
		logic [pcc_pkg::COLOR_W-1:0] carried;
		reply = '0;
		case (cmd.op)
			pcc_pkg::OP_TICK: begin
				if (model_enable) begin
					any = 1'b0;
					for (r = 0; r < pcc_pkg::RANGE_COUNT_DEF; r++) begin
						rate = model_rate[r];
						if (rate != 0) begin
							if (rate > pcc_pkg::ONE_PER_TICK)
								rate = pcc_pkg::ONE_PER_TICK;
							acc = model_phase[r] + rate;
							if (acc >= pcc_pkg::ONE_PER_TICK) begin
								acc = acc - pcc_pkg::ONE_PER_TICK;
								// rotate low..high up by one; low above high copies high into low
								lo = model_bounds[r][9:5];
								hi = model_bounds[r][4:0];
								carried = model_palette[hi];
								for (j = hi; j > lo; j--)
									model_palette[j] = model_palette[j - 1];
								model_palette[lo] = carried;
								any = 1'b1;
							end
							model_phase[r] = pcc_pkg::PHASE_W'(acc);
						end
					end
					reply.changed = any && !model_suppress;
				end
			end
			pcc_pkg::OP_WRITE: model_palette[cmd.idx] = cmd.color;
			pcc_pkg::OP_READ: reply.color = model_palette[cmd.idx];
			default: ;
		endcase
		return reply;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic add_cmd(input logic [pcc_pkg::OP_W-1:0] op,
			input logic [pcc_pkg::IDX_W-1:0] idx, input logic [pcc_pkg::COLOR_W-1:0] color);
		cmd_queue.push_back('{op: op, idx: idx, color: color});
	endtask

	// Write one register and mirror it into the predictor
	task automatic write_reg(input int idx, input int unsigned val);
		int k;
		k = (idx - pcc_pkg::CFG_RANGE_BASE) / 2;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= pcc_pkg::CFG_DATA_W'(val);
		if (idx == pcc_pkg::CFG_ENABLE)
			model_enable = val[0];
		else if (idx == pcc_pkg::CFG_SUPPRESS)
			model_suppress = val[0];
		else if ((idx - pcc_pkg::CFG_RANGE_BASE) % 2 == 0)
			model_rate[k] = pcc_pkg::RATE_W'(val);
		else
			model_bounds[k] = pcc_pkg::BOUNDS_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every command is sent and answered, then let the block settle
	task automatic drain();
		do
			@(negedge clk);
		while (cmd_queue.size() != 0 || s_tvalid || replies_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Source side: offer queued commands, idle a drawn number of cycles after each beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap != 0) begin
				s_tvalid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (cmd_queue.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= pcc_pkg::S_TDATA_W'({cmd_queue[0].color, cmd_queue[0].idx});
				s_tuser <= cmd_queue[0].op;
				void'(cmd_queue.pop_front());
				src_gap <= src_idle ? $urandom_range(0, 13) : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off once, partway through the random traffic
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Sink side: stall a drawn number of cycles after each result beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
		end else if (m_tready) begin
			if (m_tvalid) begin
				draw = sink_idle ? $urandom_range(0, 13) : 0;
				m_tready <= (draw == 0);
				sink_gap <= (draw == 0) ? 0 : draw - 1;
			end
		end else if (sink_gap == 0) begin
			m_tready <= 1'b1;
		end else begin
			sink_gap <= sink_gap - 1;
		end
	end

	// Predict the reply for every accepted command beat
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			replies_due.push_back(apply_palette_cmd('{op: s_tuser, idx: s_tdata[4:0],
				color: s_tdata[16:5]}));
			beats_in <= beats_in + 1;
		end
	end

	// Compare each result beat with the oldest predicted reply
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (replies_due.size() == 0) begin
				flag_mismatch($sformatf("result beat %h with no reply pending", m_tdata));
			end else begin
				want = replies_due.pop_front();
				if (m_tdata[0] !== want.changed)
					flag_mismatch($sformatf("changed %b, expected %b", m_tdata[0], want.changed));
				if (m_tdata[12:1] !== want.color)
					flag_mismatch($sformatf("read_color %h, expected %h", m_tdata[12:1],
						want.color));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("palette_color_cycler_top_tb: FAIL");
		$finish;
	end

	initial begin
		int ph;
		int r;
		int n;
		int unsigned pick;
		int unsigned rate;
		int unsigned bnd;
		logic en;
		logic sup;

		model_enable = 1'b0;
		model_suppress = 1'b0;
		for (r = 0; r < pcc_pkg::RANGE_COUNT_DEF; r++) begin
			model_rate[r] = pcc_pkg::RATE_RESET;
			model_bounds[r] = (r == 0) ? pcc_pkg::BOUNDS_FIRST_RESET : pcc_pkg::BOUNDS_RESET;
			model_phase[r] = '0;
		end
		for (n = 0; n < pcc_pkg::PALETTE_DEPTH_DEF; n++)
			model_palette[n] = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: cleared palette, ticks ignored, unused op gives zeros
		add_cmd(pcc_pkg::OP_READ, 5'd0, 12'hFFF);
		add_cmd(pcc_pkg::OP_READ, 5'd31, 12'h000);
		add_cmd(pcc_pkg::OP_WRITE, 5'd0, 12'hFFF);
		add_cmd(pcc_pkg::OP_WRITE, 5'd31, 12'h5A5);
		for (n = 1; n <= 9; n++)
			add_cmd(pcc_pkg::OP_WRITE, pcc_pkg::IDX_W'(n), pcc_pkg::COLOR_W'(12'h111 * n));
		add_cmd(pcc_pkg::OP_TICK, 5'd31, 12'hFFF);
		add_cmd(OP_UNUSED, 5'd31, 12'hFFF);
		drain();

		// Full-step rate, rate above one step, low above high, inactive range
		write_reg(pcc_pkg::CFG_ENABLE, 1);
		write_reg(pcc_pkg::CFG_RANGE_BASE, pcc_pkg::ONE_PER_TICK);
		write_reg(pcc_pkg::CFG_RANGE_BASE + 1, (2 << 5) | 6);
		write_reg(pcc_pkg::CFG_RANGE_BASE + 2, 32767);
		write_reg(pcc_pkg::CFG_RANGE_BASE + 3, (9 << 5) | 4);
		write_reg(pcc_pkg::CFG_RANGE_BASE + 4, 0);
		write_reg(pcc_pkg::CFG_RANGE_BASE + 5, 1023);
		add_cmd(pcc_pkg::OP_TICK, 5'd0, 12'h000);
		add_cmd(pcc_pkg::OP_TICK, 5'd0, 12'h000);
		add_cmd(pcc_pkg::OP_READ, 5'd2, 12'h000);
		add_cmd(pcc_pkg::OP_READ, 5'd6, 12'h000);
		add_cmd(pcc_pkg::OP_READ, 5'd9, 12'h000);
		drain();

		// Whole-palette range at half rate, single-entry range still counts as a change
		write_reg(pcc_pkg::CFG_SUPPRESS, 0);
		write_reg(pcc_pkg::CFG_RANGE_BASE, 0);
		write_reg(pcc_pkg::CFG_RANGE_BASE + 2, 8192);
		write_reg(pcc_pkg::CFG_RANGE_BASE + 3, 31);
		write_reg(pcc_pkg::CFG_RANGE_BASE + 4, pcc_pkg::ONE_PER_TICK);
		write_reg(pcc_pkg::CFG_RANGE_BASE + 5, (5 << 5) | 5);
		add_cmd(pcc_pkg::OP_TICK, 5'd0, 12'h000);
		add_cmd(pcc_pkg::OP_TICK, 5'd0, 12'h000);
		add_cmd(pcc_pkg::OP_READ, 5'd0, 12'h000);
		add_cmd(pcc_pkg::OP_READ, 5'd31, 12'h000);
		add_cmd(pcc_pkg::OP_READ, 5'd5, 12'h000);
		drain();

		// Random traffic under a fresh register setting per phase
		for (ph = 0; ph < 10; ph++) begin
			src_idle = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			en = (ph < 2) ? 1'b1 : ($urandom_range(0, 5) != 0);
			sup = (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : ($urandom_range(0, 3) == 0);
			write_reg(pcc_pkg::CFG_ENABLE, en);
			write_reg(pcc_pkg::CFG_SUPPRESS, sup);
			for (r = 0; r < pcc_pkg::RANGE_COUNT_DEF; r++) begin
				bnd = $urandom_range(0, 1023);
				if (ph == 0) begin
					rate = 32767;
					bnd = (r == 0) ? 31 : (r == 1) ? 1023 : 0;
				end else if (ph == 1) begin
					rate = 0;
				end else begin
					case ($urandom_range(0, 5))
						0: rate = 0;
						1: rate = pcc_pkg::ONE_PER_TICK;
						2: rate = $urandom_range(1, pcc_pkg::ONE_PER_TICK);
						3: rate = $urandom_range(pcc_pkg::ONE_PER_TICK + 1, 32767);
						4: rate = $urandom_range(1, 64);
						default: rate = $urandom_range(4000, 12000);
					endcase
				end
				write_reg(pcc_pkg::CFG_RANGE_BASE + 2 * r, rate);
				write_reg(pcc_pkg::CFG_RANGE_BASE + 2 * r + 1, bnd);
			end
			for (n = 0; n < 65; n++) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					add_cmd(OP_UNUSED, pcc_pkg::IDX_W'($urandom),
						pcc_pkg::COLOR_W'($urandom));
				else if (pick < 8)
					add_cmd(pcc_pkg::OP_TICK, pcc_pkg::IDX_W'($urandom),
						pcc_pkg::COLOR_W'($urandom));
				else if (pick < 14)
					add_cmd(pcc_pkg::OP_WRITE, pcc_pkg::IDX_W'($urandom),
						pcc_pkg::COLOR_W'($urandom));
				else
					add_cmd(pcc_pkg::OP_READ, pcc_pkg::IDX_W'($urandom),
						pcc_pkg::COLOR_W'($urandom));
			end
			drain();
		end

		if (mismatch_count == 0)
			$display("palette_color_cycler_top_tb: PASS");
		else
			$display("palette_color_cycler_top_tb: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/pcc_pkg.sv
hdl/pcc_ctrl.sv
hdl/pcc_datapath.sv
hdl/palette_color_cycler_top.sv
hdl/pcc_checker.sv
dv/palette_color_cycler_top_tb.sv
